@@ rtl/core/sss_pkg.sv @@
// ----------------------------------------------------------------------------
// sss_pkg
// Shared types and constants of the scanline span set.
// ----------------------------------------------------------------------------
package sss_pkg;

    // default sizes
    localparam int LINE_CNT_DEF  = 512;
    localparam int MAX_SPANS_DEF = 16;
    localparam int PIXEL_CNT     = 1024;

    // field widths
    localparam int PX_W  = 10;
    localparam int CNT_W = 7;
    localparam int TOP_W = 9;

    // item kinds carried in tuser
    typedef enum logic [1:0] {
        KIND_ADD   = 2'd0,
        KIND_DEL   = 2'd1,
        KIND_QUERY = 2'd2,
        KIND_CLEAR = 2'd3
    } kind_t;

    // register index (paddr[3:2])
    typedef enum logic [1:0] {
        REG_TOP    = 2'd0,
        REG_BOTTOM = 2'd1,
        REG_LEFT   = 2'd2,
        REG_RIGHT  = 2'd3
    } reg_idx_t;

    // per-line summary word
    typedef struct packed {
        logic [CNT_W-1:0] cnt;
        logic [PX_W-1:0]  left;
        logic [PX_W-1:0]  right;
    } line_sum_t;

    // one stored span
    typedef struct packed {
        logic [PX_W-1:0] s;
        logic [PX_W-1:0] e;
    } span_t;

endpackage

@@ rtl/core/sss_span_ram.sv @@
// ----------------------------------------------------------------------------
// sss_span_ram
// Simple dual-port span memory, one write and one registered read port.
// ----------------------------------------------------------------------------
module sss_span_ram
    import sss_pkg::*;
#(
    parameter int DEPTH = MAX_SPANS_DEF
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  span_t                    wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output span_t                    rdata
);

    span_t mem [DEPTH];

    // write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge aclk) begin
        rdata <= mem[raddr];
    end

endmodule

@@ rtl/core/sss_line_mem.sv @@
// ----------------------------------------------------------------------------
// sss_line_mem
// Per-line summary memory (count, leftmost, rightmost) with a clearing sweep
// that runs after reset and on request.
// ----------------------------------------------------------------------------
module sss_line_mem
    import sss_pkg::*;
#(
    parameter int LINE_CNT = LINE_CNT_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        clr_start,
    output logic                        busy,
    input  logic [$clog2(LINE_CNT)-1:0] raddr,
    output line_sum_t                   rdata,
    input  logic                        we,
    input  logic [$clog2(LINE_CNT)-1:0] waddr,
    input  line_sum_t                   wdata
);

    localparam int LW = $clog2(LINE_CNT);

    line_sum_t      mem [LINE_CNT];
    logic           busy_reg;
    logic [LW-1:0]  ptr_reg;

    // sweep control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b1;
            ptr_reg  <= '0;
        end else if (clr_start) begin
            busy_reg <= 1'b1;
            ptr_reg  <= '0;
        end else if (busy_reg) begin
            if (ptr_reg == LW'(LINE_CNT - 1)) begin
                busy_reg <= 1'b0;
            end
            ptr_reg <= ptr_reg + 1'b1;
        end
    end

    // write port, shared by the sweep
    always_ff @(posedge aclk) begin
        if (busy_reg) begin
            mem[ptr_reg] <= '0;
        end else if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge aclk) begin
        rdata <= mem[raddr];
    end

    assign busy = busy_reg;

endmodule

@@ rtl/core/scanline_span_set.sv @@
// ----------------------------------------------------------------------------
// scanline_span_set
// Sorted, disjoint pixel spans per scanline with add, delete, query, clear.
// ----------------------------------------------------------------------------
// One item is worked on at a time. For add, delete and query the line's
// summary is read first, then the span list is walked through the single
// read port of the span memory, one span a cycle, save that add and delete
// pause the walk in ST_EMIT2 where two spans come out of one. Add and
// delete write the new list into a scratch memory and copy it back. A
// clear, and the pass after reset, sweep the summary memory one line a
// cycle, and no item is taken during the sweep. Configuration writes are
// taken at any time.
// ----------------------------------------------------------------------------
module scanline_span_set
    import sss_pkg::*;
#(
    parameter int LINE_CNT  = LINE_CNT_DEF,
    parameter int MAX_SPANS = MAX_SPANS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input items
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,  // first_px[12:0], end_px[25:13], line[36:26]
    input  logic [1:0]  s_tuser,  // kind[1:0]
    // result items
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,  // hit[0], spans[5:1], leftmost_px[15:6],
                                  // rightmost_px[25:16], overflow[26]
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int LW = $clog2(LINE_CNT);
    localparam int AW = $clog2(LINE_CNT * MAX_SPANS);
    localparam int SW = $clog2(MAX_SPANS);

    typedef enum logic [7:0] {
        ST_IDLE  = 8'b0000_0001,
        ST_SUM   = 8'b0000_0010,
        ST_SCAN  = 8'b0000_0100,
        ST_EMIT2 = 8'b0000_1000,
        ST_QSCAN = 8'b0001_0000,
        ST_COPY  = 8'b0010_0000,
        ST_CLR   = 8'b0100_0000,
        ST_DONE  = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;

    // configuration registers
    logic [TOP_W-1:0] top_reg, bot_reg;
    logic [PX_W-1:0]  left_reg, right_reg;
    logic             cfg_we;

    assign pready = 1'b1;
    assign cfg_we = psel & penable & pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            top_reg   <= '0;
            bot_reg   <= '1;
            left_reg  <= '0;
            right_reg <= '1;
        end else if (cfg_we) begin
            case (reg_idx_t'(paddr[3:2]))
                REG_TOP:    top_reg   <= pwdata[TOP_W-1:0];
                REG_BOTTOM: bot_reg   <= pwdata[TOP_W-1:0];
                REG_LEFT:   left_reg  <= pwdata[PX_W-1:0];
                REG_RIGHT:  right_reg <= pwdata[PX_W-1:0];
                default:    top_reg   <= top_reg;
            endcase
        end
    end

    // register readback
    always_comb begin
        case (reg_idx_t'(paddr[3:2]))
            REG_TOP:    prdata = 32'(top_reg);
            REG_BOTTOM: prdata = 32'(bot_reg);
            REG_LEFT:   prdata = 32'(left_reg);
            REG_RIGHT:  prdata = 32'(right_reg);
            default:    prdata = '0;
        endcase
    end

    // input decode, swap and clip
    kind_t              in_kind;
    logic signed [12:0] in_s, in_e;
    logic signed [10:0] in_line;
    logic signed [13:0] s14, e14, lo14, hi14, ln14, top14, bot14, lft14, rgt14;
    logic               line_ok, in_region, accept;
    logic [PX_W-1:0]    clip_s, clip_e;
    logic [LW-1:0]      line_idx;

    assign in_kind = kind_t'(s_tuser);
    assign in_s    = $signed(s_tdata[12:0]);
    assign in_e    = $signed(s_tdata[25:13]);
    assign in_line = $signed(s_tdata[36:26]);
    assign accept  = s_tvalid & s_tready;

    always_comb begin
        s14   = 14'(in_s);
        e14   = 14'(in_e);
        ln14  = 14'(in_line);
        top14 = $signed({5'd0, top_reg});
        lft14 = $signed({4'd0, left_reg});
        bot14 = (int'(bot_reg) > LINE_CNT - 1) ? 14'(LINE_CNT - 1)
                                               : $signed({5'd0, bot_reg});
        rgt14 = (int'(right_reg) > PIXEL_CNT - 1) ? 14'(PIXEL_CNT - 1)
                                                  : $signed({4'd0, right_reg});
        lo14  = (e14 < s14) ? e14 : s14;
        hi14  = (e14 < s14) ? s14 : e14;
        line_ok   = (ln14 >= 14'sd0) && (ln14 < 14'(LINE_CNT));
        in_region = (ln14 >= top14) && (ln14 <= bot14) && (lft14 <= rgt14) &&
                    (hi14 >= lft14) && (lo14 <= rgt14);
        clip_s   = (lo14 < lft14) ? lft14[PX_W-1:0] : lo14[PX_W-1:0];
        clip_e   = (hi14 > rgt14) ? rgt14[PX_W-1:0] : hi14[PX_W-1:0];
        line_idx = LW'(32'(in_line[9:0]));
    end

    // item registers
    kind_t              kind_reg;
    logic signed [12:0] sraw_reg;
    logic [PX_W-1:0]    cs_reg, ce_reg, ms_reg, me_reg;
    logic [LW-1:0]      line_reg;
    logic               act_reg, merged_reg, placed_reg, upd_reg;
    logic [CNT_W-1:0]   n_reg, i_reg, k_reg, c_reg;
    logic [PX_W-1:0]    new_left_reg, new_right_reg;
    span_t              hold_reg;
    logic               res_hit_reg, res_ovf_reg;
    logic [CNT_W-1:0]   res_cnt_reg;
    logic [PX_W-1:0]    res_left_reg, res_right_reg;
    logic               m_valid_reg;
    logic [31:0]        m_data_reg;

    // summary memory
    line_sum_t sum_rdata, sum_wdata;
    logic      clr_busy, sum_we;

    assign sum_we    = (state_reg == ST_DONE) && upd_reg;
    assign sum_wdata = '{cnt: res_cnt_reg, left: res_left_reg, right: res_right_reg};

    sss_line_mem #(
        .LINE_CNT  (LINE_CNT)
    ) u_line_mem (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .clr_start (accept && (in_kind == KIND_CLEAR)),
        .busy      (clr_busy),
        .raddr     ((state_reg == ST_IDLE) ? line_idx : line_reg),
        .rdata     (sum_rdata),
        .we        (sum_we),
        .waddr     (line_reg),
        .wdata     (sum_wdata)
    );

    // span memory read index
    logic [CNT_W-1:0] rd_idx;
    logic [SW-1:0]    rd_sel, scr_rsel, scr_wsel;
    logic [AW-1:0]    main_raddr, main_waddr;
    span_t            cur, scr_rdata, scr_wdata;
    logic             main_we, scr_we;

    always_comb begin
        case (state_reg)
            ST_SCAN, ST_QSCAN: rd_idx = i_reg + 1'b1;
            ST_EMIT2:          rd_idx = i_reg;
            default:           rd_idx = '0;
        endcase
        rd_sel     = (int'(rd_idx) < MAX_SPANS) ? SW'(rd_idx) : '0;
        main_raddr = AW'(32'(line_reg) * MAX_SPANS + 32'(rd_sel));
        main_waddr = AW'(32'(line_reg) * MAX_SPANS + 32'(c_reg) - 32'd1);
        scr_rsel   = (int'(c_reg) < MAX_SPANS) ? SW'(c_reg) : '0;
        scr_wsel   = SW'(k_reg);
    end

    // copy back from scratch
    assign main_we = (state_reg == ST_COPY) && (c_reg != '0);

    sss_span_ram #(
        .DEPTH (LINE_CNT * MAX_SPANS)
    ) u_span_ram (
        .aclk  (aclk),
        .we    (main_we),
        .waddr (main_waddr),
        .wdata (scr_rdata),
        .raddr (main_raddr),
        .rdata (cur)
    );

    // walk step over one stored span
    logic [1:0]  nw;
    span_t       w1, w2;
    logic        fin, merge_now, place_now, ovf_fin, below, above, q_hit;
    logic [CNT_W-1:0] k_fin;

    always_comb begin
        nw        = 2'd0;
        w1        = cur;
        w2        = cur;
        merge_now = 1'b0;
        place_now = 1'b0;
        fin       = (i_reg == n_reg);
        below     = ({1'b0, cur.e} + 11'd1) < {1'b0, cs_reg};
        above     = {1'b0, cur.s} > ({1'b0, ce_reg} + 11'd1);
        if (kind_reg == KIND_ADD) begin
            if (fin) begin
                if (!placed_reg) begin
                    nw = 2'd1;
                    w1 = '{s: ms_reg, e: me_reg};
                end
            end else if (below) begin
                nw = 2'd1;
            end else if (above && !placed_reg) begin
                nw        = 2'd2;
                w1        = '{s: ms_reg, e: me_reg};
                place_now = 1'b1;
            end else if (above) begin
                nw = 2'd1;
            end else begin
                merge_now = 1'b1;
            end
        end else if (!fin) begin
            if ((cur.e < cs_reg) || (cur.s > ce_reg)) begin
                nw = 2'd1;
            end else if ((cur.s < cs_reg) && (cur.e > ce_reg)) begin
                nw = 2'd2;
                w1 = '{s: cur.s, e: cs_reg - 1'b1};
                w2 = '{s: ce_reg + 1'b1, e: cur.e};
            end else if (cur.s < cs_reg) begin
                nw = 2'd1;
                w1 = '{s: cur.s, e: cs_reg - 1'b1};
            end else if (cur.e > ce_reg) begin
                nw = 2'd1;
                w1 = '{s: ce_reg + 1'b1, e: cur.e};
            end
        end
        k_fin   = k_reg + CNT_W'(nw != 2'd0);
        ovf_fin = (kind_reg == KIND_ADD) ? (!merged_reg && (int'(n_reg) >= MAX_SPANS))
                                         : (int'(k_reg) > MAX_SPANS);
        q_hit   = (14'(sraw_reg) >= $signed({4'd0, cur.s})) &&
                  (14'(sraw_reg) <= $signed({4'd0, cur.e}));
    end

    // scratch list of the new spans
    assign scr_we    = ((state_reg == ST_SCAN && nw != 2'd0) || state_reg == ST_EMIT2) &&
                       (int'(k_reg) < MAX_SPANS);
    assign scr_wdata = (state_reg == ST_EMIT2) ? hold_reg : w1;

    sss_span_ram #(
        .DEPTH (MAX_SPANS)
    ) u_scratch (
        .aclk  (aclk),
        .we    (scr_we),
        .waddr (scr_wsel),
        .wdata (scr_wdata),
        .raddr (scr_rsel),
        .rdata (scr_rdata)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (in_kind == KIND_CLEAR) state_next = ST_CLR;
                    else if (!line_ok)         state_next = ST_DONE;
                    else                       state_next = ST_SUM;
                end
            end
            ST_SUM: begin
                if (kind_reg == KIND_QUERY)
                    state_next = (sum_rdata.cnt != '0) ? ST_QSCAN : ST_DONE;
                else
                    state_next = act_reg ? ST_SCAN : ST_DONE;
            end
            ST_SCAN: begin
                if (fin)
                    state_next = (ovf_fin || k_fin == '0) ? ST_DONE : ST_COPY;
                else if (nw == 2'd2)
                    state_next = ST_EMIT2;
            end
            ST_EMIT2: state_next = ST_SCAN;
            ST_QSCAN: begin
                if (q_hit || (i_reg + 1'b1 == n_reg)) state_next = ST_DONE;
            end
            ST_COPY: begin
                if (c_reg == k_reg) state_next = ST_DONE;
            end
            ST_CLR: begin
                if (!clr_busy) state_next = ST_DONE;
            end
            ST_DONE: begin
                if (!m_valid_reg || m_tready) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_DONE && (!m_valid_reg || m_tready))
                m_valid_reg <= 1'b1;
            else if (m_tready)
                m_valid_reg <= 1'b0;
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    kind_reg      <= in_kind;
                    sraw_reg      <= in_s;
                    cs_reg        <= clip_s;
                    ce_reg        <= clip_e;
                    ms_reg        <= clip_s;
                    me_reg        <= clip_e;
                    line_reg      <= line_idx;
                    act_reg       <= in_region &&
                                     (in_kind == KIND_ADD || in_kind == KIND_DEL);
                    merged_reg    <= 1'b0;
                    placed_reg    <= 1'b0;
                    upd_reg       <= 1'b0;
                    i_reg         <= '0;
                    k_reg         <= '0;
                    c_reg         <= '0;
                    new_left_reg  <= '0;
                    new_right_reg <= '0;
                    res_hit_reg   <= 1'b0;
                    res_ovf_reg   <= 1'b0;
                    res_cnt_reg   <= '0;
                    res_left_reg  <= '0;
                    res_right_reg <= '0;
                end
            end
            ST_SUM: begin
                n_reg         <= sum_rdata.cnt;
                res_cnt_reg   <= sum_rdata.cnt;
                res_left_reg  <= sum_rdata.left;
                res_right_reg <= sum_rdata.right;
            end
            ST_SCAN: begin
                hold_reg <= w2;
                if (merge_now) begin
                    merged_reg <= 1'b1;
                    if (cur.s < ms_reg) ms_reg <= cur.s;
                    if (cur.e > me_reg) me_reg <= cur.e;
                end
                if (place_now) placed_reg <= 1'b1;
                if (nw != 2'd0) begin
                    k_reg         <= k_reg + 1'b1;
                    new_right_reg <= w1.e;
                    if (k_reg == '0) new_left_reg <= w1.s;
                end
                if (!fin) begin
                    i_reg <= i_reg + 1'b1;
                end else if (ovf_fin) begin
                    res_ovf_reg <= 1'b1;
                end else begin
                    upd_reg     <= 1'b1;
                    res_cnt_reg <= k_fin;
                    if (k_fin == '0) begin
                        res_left_reg  <= '0;
                        res_right_reg <= '0;
                    end else begin
                        res_left_reg  <= (k_reg == '0) ? w1.s : new_left_reg;
                        res_right_reg <= (nw != 2'd0) ? w1.e : new_right_reg;
                    end
                end
            end
            ST_EMIT2: begin
                k_reg         <= k_reg + 1'b1;
                new_right_reg <= hold_reg.e;
            end
            ST_QSCAN: begin
                i_reg <= i_reg + 1'b1;
                if (q_hit) res_hit_reg <= 1'b1;
            end
            ST_COPY: begin
                c_reg <= c_reg + 1'b1;
            end
            ST_DONE: begin
                if (!m_valid_reg || m_tready) begin
                    m_data_reg <= {5'd0, res_ovf_reg, res_right_reg, res_left_reg,
                                   res_cnt_reg[4:0], res_hit_reg};
                end
            end
            default: begin
                c_reg <= c_reg;
            end
        endcase
    end

    assign s_tready = (state_reg == ST_IDLE) && !clr_busy;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

@@ rtl/core/sss_chk.sv @@
// ----------------------------------------------------------------------------
// sss_chk
// Port-level checks of the scanline span set, bound to the top level.
// ----------------------------------------------------------------------------
module sss_chk
    import sss_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata
);

    // a stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // one item at a time
    a_one: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("item taken while another is in work");

    // an empty line reports no pixels
    a_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[5:1] == 5'd0) |-> (m_tdata[25:6] == 20'd0))
        else $error("empty line with pixel extent");

    // hit and overflow never together
    a_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[0] && m_tdata[26]))
        else $error("hit and overflow both set");

    // clearing pass follows reset
    a_init: assert property (@(posedge aclk)
        $rose(aresetn) |-> !s_tready && !m_tvalid)
        else $error("ready during clearing pass");

endmodule

bind scanline_span_set sss_chk u_sss_chk (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

@@ verif/scanline_span_set_tb.sv @@
// ----------------------------------------------------------------------------
// scanline_span_set_tb
// Drives add, delete, query and clear items through the stream ports, keeps
// a software image of every line's span list and checks each result item
// field by field. Region registers are rewritten between phases.
// ----------------------------------------------------------------------------
module scanline_span_set_tb;
    import sss_pkg::*;

    localparam int LINES = 512;
    localparam int SPANS = 16;
    localparam int PIXELS = 1024;

    typedef struct packed {
        logic       hit;
        logic [4:0] cnt;
        logic [9:0] lft;
        logic [9:0] rgt;
        logic       ovf;
    } span_res_t;

    // software image of the span store and region
    class span_scoreboard;
        int          sp_s[LINES][$];
        int          sp_e[LINES][$];
        int          top_ln, bot_ln, lft_px, rgt_px;
        span_res_t   pending[$];
        int          errors;

        function new();
            top_ln = 0; bot_ln = 511; lft_px = 0; rgt_px = 1023;
            errors = 0;
        endfunction

        function void set_reg(reg_idx_t idx, int v);
            case (idx)
                REG_TOP:    top_ln = v & 'h1ff;
                REG_BOTTOM: bot_ln = v & 'h1ff;
                REG_LEFT:   lft_px = v & 'h3ff;
                default:    rgt_px = v & 'h3ff;
            endcase
        endfunction

        function bit add_span(int ln, int s, int e);
            int ns[$], ne[$];
            int ms, me, n;
            bit merged, placed;
            ms = s; me = e; merged = 0; placed = 0;
            n = sp_s[ln].size();
            for (int i = 0; i < n; i++)
                if (sp_e[ln][i] + 1 >= s && sp_s[ln][i] <= e + 1) begin
                    merged = 1;
                    if (sp_s[ln][i] < ms) ms = sp_s[ln][i];
                    if (sp_e[ln][i] > me) me = sp_e[ln][i];
                end
            if (!merged && n >= SPANS) return 1;
            for (int i = 0; i < n; i++) begin
                if (sp_e[ln][i] + 1 < s) begin
                    ns.push_back(sp_s[ln][i]); ne.push_back(sp_e[ln][i]);
                end else if (sp_s[ln][i] > e + 1) begin
                    if (!placed) begin
                        ns.push_back(ms); ne.push_back(me); placed = 1;
                    end
                    ns.push_back(sp_s[ln][i]); ne.push_back(sp_e[ln][i]);
                end
            end
            if (!placed) begin
                ns.push_back(ms); ne.push_back(me);
            end
            sp_s[ln] = ns; sp_e[ln] = ne;
            return 0;
        endfunction

        function bit cut_span(int ln, int s, int e);
            int ns[$], ne[$];
            for (int i = 0; i < sp_s[ln].size(); i++) begin
                if (sp_e[ln][i] < s || sp_s[ln][i] > e) begin
                    ns.push_back(sp_s[ln][i]); ne.push_back(sp_e[ln][i]);
                    continue;
                end
                if (sp_s[ln][i] < s) begin
                    ns.push_back(sp_s[ln][i]); ne.push_back(s - 1);
                end
                if (sp_e[ln][i] > e) begin
                    ns.push_back(e + 1); ne.push_back(sp_e[ln][i]);
                end
            end
            if (ns.size() > SPANS) return 1;
            sp_s[ln] = ns; sp_e[ln] = ne;
            return 0;
        endfunction

        // note one accepted input item and queue its result
        function void note_item(kind_t k, logic signed [12:0] sp,
                                logic signed [12:0] ep, logic signed [10:0] lp);
            int s, e, ln, bot, rgt, t, n;
            bit ok;
            span_res_t r;
            s = sp; e = ep; ln = lp;
            ok = (ln >= 0 && ln < LINES);
            r = '0;
            if (k == KIND_CLEAR) begin
                foreach (sp_s[i]) begin
                    sp_s[i].delete(); sp_e[i].delete();
                end
            end else if (k == KIND_QUERY) begin
                if (ok)
                    for (int i = 0; i < sp_s[ln].size(); i++)
                        if (s >= sp_s[ln][i] && s <= sp_e[ln][i]) r.hit = 1;
            end else if (ok) begin
                bot = bot_ln > LINES - 1 ? LINES - 1 : bot_ln;
                rgt = rgt_px > PIXELS - 1 ? PIXELS - 1 : rgt_px;
                if (e < s) begin
                    t = s; s = e; e = t;
                end
                if (ln >= top_ln && ln <= bot && lft_px <= rgt &&
                    e >= lft_px && s <= rgt) begin
                    if (s < lft_px) s = lft_px;
                    if (e > rgt) e = rgt;
                    r.ovf = (k == KIND_ADD) ? add_span(ln, s, e) : cut_span(ln, s, e);
                end
            end
            if (ok) begin
                n = sp_s[ln].size();
                r.cnt = 5'(n);
                r.lft = n ? 10'(sp_s[ln][0]) : 10'd0;
                r.rgt = n ? 10'(sp_e[ln][n-1]) : 10'd0;
            end
            pending.push_back(r);
        endfunction

        // compare one result item with the oldest expectation
        function void check_result(logic [31:0] d);
            span_res_t x;
            if (pending.size() == 0) begin
                $error("result item with nothing expected: %h", d);
                errors++;
                return;
            end
            x = pending.pop_front();
            if (d[0] !== x.hit) begin
                $error("hit exp %0d got %0d", x.hit, d[0]); errors++;
            end
            if (d[5:1] !== x.cnt) begin
                $error("spans exp %0d got %0d", x.cnt, d[5:1]); errors++;
            end
            if (d[15:6] !== x.lft) begin
                $error("leftmost_px exp %0d got %0d", x.lft, d[15:6]); errors++;
            end
            if (d[25:16] !== x.rgt) begin
                $error("rightmost_px exp %0d got %0d", x.rgt, d[25:16]); errors++;
            end
            if (d[26] !== x.ovf) begin
                $error("overflow exp %0d got %0d", x.ovf, d[26]); errors++;
            end
        endfunction
    endclass

    logic        aclk = 0, aresetn = 0;
    logic        s_tvalid = 0, s_tready;
    logic [39:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid, m_tready = 0;
    logic [31:0] m_tdata;
    logic        psel = 0, penable = 0, pwrite = 0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0, prdata;
    logic        pready;

    span_scoreboard sb;
    bit          calm = 0;   // no idling in the last part
    int          lo_line = 0, hi_line = 3;

    scanline_span_set dut (.*);

    always begin
        #6 aclk = 1;
        #6 aclk = 0;
    end

    // result side: random stalls, check on each accepted item
    initial begin
        int gap;
        forever begin
            @(negedge aclk);
            if (!calm && $urandom_range(0, 9) == 0) begin
                m_tready <= 0;
                gap = $urandom_range(1, 18);
                repeat (gap) @(negedge aclk);
            end
            m_tready <= 1;
        end
    end

    always @(posedge aclk)
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata);

    task automatic reg_write(reg_idx_t idx, int v);
        @(negedge aclk);
        psel <= 1; pwrite <= 1; penable <= 0;
        paddr <= {idx, 2'b00}; pwdata <= v;
        @(negedge aclk);
        penable <= 1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        sb.set_reg(idx, v);
        @(negedge aclk);
        psel <= 0; penable <= 0; pwrite <= 0;
    endtask

    // tvalid stays high after the accept until the next item or an idle;
    // the block is busy then, so nothing is taken twice
    task automatic send_item(kind_t k, int s, int e, int ln);
        logic [12:0] sv, ev;
        logic [10:0] lv;
        sv = 13'(s); ev = 13'(e); lv = 11'(ln);
        if (!calm && $urandom_range(0, 7) == 0) begin
            s_tvalid <= 0;
            repeat ($urandom_range(1, 18)) @(negedge aclk);
        end
        s_tvalid <= 1;
        s_tuser <= k;
        s_tdata <= {3'b0, lv, ev, sv};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_item(k, sv, ev, lv);
        @(negedge aclk);
    endtask

    task automatic drain();
        s_tvalid <= 0;
        while (sb.pending.size() != 0) @(negedge aclk);
        repeat (60) @(negedge aclk);
    endtask

    task automatic random_item();
        int r, s, e, ln;
        kind_t k;
        r = $urandom_range(0, 99);
        k = r < 50 ? KIND_ADD : r < 72 ? KIND_DEL : r < 99 ? KIND_QUERY : KIND_CLEAR;
        if ($urandom_range(0, 19) == 0) begin
            s = $urandom_range(0, 8191) - 4096;
            e = $urandom_range(0, 8191) - 4096;
            ln = $urandom_range(0, 2047) - 1024;
        end else begin
            s = $urandom_range(0, 1023);
            e = s + $urandom_range(0, 60);
            if ($urandom_range(0, 3) == 0) e = s - $urandom_range(0, 30);
            ln = $urandom_range(lo_line, hi_line);
        end
        send_item(k, s, e, ln);
    endtask

    initial begin
        sb = new();
        repeat (2) @(negedge aclk);
        aresetn <= 1;

        // directed: extremes, each kind, reversed ends, bad lines, full line
        send_item(KIND_QUERY, 0, 0, 0);
        send_item(KIND_ADD, 4095, -4096, 0);
        send_item(KIND_QUERY, 1023, 0, 0);
        send_item(KIND_DEL, 100, 50, 0);
        send_item(KIND_QUERY, 75, 0, 0);
        send_item(KIND_ADD, 5, 5, -1024);
        send_item(KIND_ADD, 5, 5, 1023);
        send_item(KIND_QUERY, 5, -1, 512);
        send_item(KIND_ADD, 5000 - 4096, -4096, 511);
        for (int i = 0; i < 17; i++) send_item(KIND_ADD, i * 4, i * 4, 1);
        send_item(KIND_DEL, 1, 1, 1);
        send_item(KIND_ADD, 1, 2, 1);
        send_item(KIND_CLEAR, -1, -1, -1);
        drain();

        // region at extremes and reversed
        reg_write(REG_TOP, 2); reg_write(REG_BOTTOM, 3);
        reg_write(REG_LEFT, 300); reg_write(REG_RIGHT, 200);
        repeat (40) random_item();
        drain();
        reg_write(REG_RIGHT, 700);
        repeat (120) random_item();
        drain();
        reg_write(REG_TOP, 511); reg_write(REG_BOTTOM, 511);
        reg_write(REG_LEFT, 1023); reg_write(REG_RIGHT, 1023);
        lo_line = 509; hi_line = 511;
        repeat (60) random_item();
        drain();
        reg_write(REG_TOP, 0); reg_write(REG_BOTTOM, 511);
        reg_write(REG_LEFT, 0); reg_write(REG_RIGHT, 1023);
        lo_line = 0; hi_line = 2;
        repeat (280) random_item();
        calm = 1;
        repeat (100) random_item();
        drain();
        if (sb.errors == 0)
            $display("scanline_span_set_tb OK");
        else
            $display("scanline_span_set_tb NOT OK");
        $finish;
    end

    initial begin
        #20000000;
        $display("scanline_span_set_tb NOT OK");
        $finish;
    end
endmodule
